// ===== design/piaw_pkg.sv =====
// types and constants shared by the pi controller with clamping anti-windup
// no dependencies; imported by piaw_ctrl, piaw_datapath and the top level
package piaw_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND   = 3'd4;

    // register reset values
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST     = 31'd65536;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST    = 31'd0;
    localparam logic [DATA_W-1:0]        SAMPLE_PERIOD_RST = 32'd429497;
    localparam logic signed [DATA_W-1:0] UPPER_BOUND_RST   = 32'sd655360;
    localparam logic signed [DATA_W-1:0] LOWER_BOUND_RST   = -32'sd655360;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P,
        ST_I,
        ST_HI,
        ST_LO,
        ST_ADD,
        ST_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_LOAD,
        STEP_P,
        STEP_I,
        STEP_HI,
        STEP_LO,
        STEP_ADD,
        STEP_COMMIT
    } step_t;

    typedef struct packed {
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/pi_controller_clamping_antiwindup.sv =====
// top level of the pi controller with clamping anti-windup
// instantiates piaw_ctrl and piaw_datapath; depends on piaw_pkg
//
// PI controller in signed Q16.16. Each input beat carries setpoint, measured
// value, an integrator reset flag and an external clamp flag; each produces one
// output beat, drive = sat(integral + Kp*error) within [lower_bound,
// upper_bound]. The integral then grows by Ki*error*Ts (saturated to Q16.16)
// unless the external clamp is set or the unsaturated output lies beyond a
// bound with Ki*error pushing further out; integ_reset zeroes it after the
// output is formed. One sample is handled at a time; from acceptance to the
// next acceptance it takes four passes through one shared 33x33 multiplier
// (Kp*e, Ki*e, and the two partial products of the Ts scaling), a step for
// the wide partial-product add and a commit step for the integrator update.
// The result sits in an output register, so the next sample is taken
// while it still waits; a stalled result holds the commit step after that.
// Config registers (index: 0 prop_gain, 1 integ_gain, 2 sample_period,
// 3 upper_bound, 4 lower_bound) are always ready and should be written
// only while no sample is in flight; other indexes are ignored.
module pi_controller_clamping_antiwindup (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [piaw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [piaw_pkg::DATA_W-1:0]           cfg_data,
    // sample input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [piaw_pkg::DATA_W-1:0]    s_setpoint,
    input  logic signed [piaw_pkg::DATA_W-1:0]    s_measured,
    input  logic                                  s_integ_reset,
    input  logic                                  s_ext_clamp,
    // drive output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [piaw_pkg::DATA_W-1:0]    m_drive
);
    import piaw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // config writes are always accepted and registered directly
    assign cfg_ready = 1'b1;

    // sequencer
    piaw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // arithmetic, integrator state and output register
    piaw_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_setpoint    (s_setpoint),
        .s_measured    (s_measured),
        .s_integ_reset (s_integ_reset),
        .s_ext_clamp   (s_ext_clamp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive       (m_drive)
    );

    // a beat taken in means the sequencer is busy on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a sample is in flight");

    // commit only when the output register is free or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step == STEP_COMMIT) |-> (!m_valid || m_ready))
        else $error("commit would overwrite a pending result");

    // every commit presents a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step == STEP_COMMIT) |=> m_valid)
        else $error("result missing after commit");

    // no load happens outside the idle cycle that accepts the beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step == STEP_LOAD) |-> (s_valid && s_ready))
        else $error("sample loaded without a handshake");

endmodule

// ===== design/piaw_ctrl.sv =====
// sequencer for the pi controller: walks one sample through the shared datapath
// depends on piaw_pkg
module piaw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output piaw_pkg::dp_cmd_t    cmd,
    input  piaw_pkg::dp_status_t status
);
    import piaw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.step   = STEP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.step   = STEP_LOAD;
                    state_next = ST_P;
                end
            end
            ST_P: begin
                cmd.step   = STEP_P;
                state_next = ST_I;
            end
            ST_I: begin
                cmd.step   = STEP_I;
                state_next = ST_HI;
            end
            ST_HI: begin
                cmd.step   = STEP_HI;
                state_next = ST_LO;
            end
            ST_LO: begin
                cmd.step   = STEP_LO;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.step   = STEP_ADD;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register can take the beat
                if (status.out_free) begin
                    cmd.step   = STEP_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/piaw_datapath.sv =====
// datapath of the pi controller: config registers, shared multiplier,
// integrator with saturation and output register; depends on piaw_pkg
module piaw_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  piaw_pkg::dp_cmd_t                     cmd,
    output piaw_pkg::dp_status_t                  status,
    input  logic                                  cfg_valid,
    input  logic [piaw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [piaw_pkg::DATA_W-1:0]           cfg_data,
    input  logic signed [piaw_pkg::DATA_W-1:0]    s_setpoint,
    input  logic signed [piaw_pkg::DATA_W-1:0]    s_measured,
    input  logic                                  s_integ_reset,
    input  logic                                  s_ext_clamp,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [piaw_pkg::DATA_W-1:0]    m_drive
);
    import piaw_pkg::*;

    // configuration
    logic [GAIN_W-1:0]        prop_gain_reg;
    logic [GAIN_W-1:0]        integ_gain_reg;
    logic [DATA_W-1:0]        sample_period_reg;
    logic signed [DATA_W-1:0] upper_bound_reg;
    logic signed [DATA_W-1:0] lower_bound_reg;

    // sample payload
    logic signed [32:0]       err_reg;
    logic                     rst_reg;
    logic                     ext_reg;

    // arithmetic pipeline
    logic signed [63:0]       prod_reg;
    logic signed [47:0]       p_reg;
    logic signed [47:0]       pre_reg;
    logic signed [48:0]       unsat_reg;
    logic signed [63:0]       hi_reg;
    logic signed [47:0]       incr_reg;
    logic signed [DATA_W-1:0] drive_val_reg;
    logic                     clamp_reg;
    logic signed [DATA_W-1:0] integ_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_drive_reg;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_p;
    logic signed [48:0]       unsat_next;
    logic signed [48:0]       upper_ext;
    logic signed [48:0]       lower_ext;
    logic                     above;
    logic                     below;
    logic                     pre_pos;
    logic                     pre_neg;
    logic signed [79:0]       add_full;
    logic signed [49:0]       sum_w;
    logic signed [DATA_W-1:0] sum_sat;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= INTEG_GAIN_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            upper_bound_reg   <= UPPER_BOUND_RST;
            lower_bound_reg   <= LOWER_BOUND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                CFG_UPPER_BOUND:   upper_bound_reg   <= $signed(cfg_data);
                CFG_LOWER_BOUND:   lower_bound_reg   <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = err_reg;
        mul_b = '0;
        case (cmd.step)
            STEP_P: begin
                mul_b = $signed({2'b00, prop_gain_reg});
            end
            STEP_I: begin
                mul_b = $signed({2'b00, integ_gain_reg});
            end
            STEP_HI: begin
                // upper 32 bits of pre, i.e. prod[63:32]
                mul_a = $signed({prod_reg[63], prod_reg[63:32]});
                mul_b = $signed({1'b0, sample_period_reg});
            end
            STEP_LO: begin
                mul_a = $signed({17'b0, pre_reg[15:0]});
                mul_b = $signed({1'b0, sample_period_reg});
            end
            default: begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign unsat_next = $signed({{17{integ_reg[31]}}, integ_reg}) + $signed({p_reg[47], p_reg});
    assign upper_ext  = $signed({{17{upper_bound_reg[31]}}, upper_bound_reg});
    assign lower_ext  = $signed({{17{lower_bound_reg[31]}}, lower_bound_reg});
    assign above      = unsat_reg > upper_ext;
    assign below      = unsat_reg < lower_ext;
    assign pre_pos    = !pre_reg[47] && (|pre_reg);
    assign pre_neg    = pre_reg[47];

    // floor((hi*2^16 + lo) / 2^32), lo is the unsigned low partial product
    assign add_full = $signed({hi_reg, 16'b0}) + $signed({{16{prod_reg[63]}}, prod_reg});

    assign sum_w = $signed({{18{integ_reg[31]}}, integ_reg})
                 + $signed({{2{incr_reg[47]}}, incr_reg});

    always_comb begin
        if (sum_w[49:31] == {19{sum_w[49]}}) begin
            sum_sat = sum_w[31:0];
        end else if (sum_w[49]) begin
            sum_sat = {1'b1, 31'b0};
        end else begin
            sum_sat = {1'b0, {31{1'b1}}};
        end
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        case (cmd.step)
            STEP_LOAD: begin
                err_reg <= $signed({s_setpoint[31], s_setpoint})
                         - $signed({s_measured[31], s_measured});
                rst_reg <= s_integ_reset;
                ext_reg <= s_ext_clamp;
            end
            STEP_P: begin
                prod_reg <= mul_p[63:0];
            end
            STEP_I: begin
                prod_reg <= mul_p[63:0];
                p_reg    <= prod_reg[63:16];
            end
            STEP_HI: begin
                prod_reg  <= mul_p[63:0];
                pre_reg   <= prod_reg[63:16];
                unsat_reg <= unsat_next;
            end
            STEP_LO: begin
                prod_reg <= mul_p[63:0];
                hi_reg   <= prod_reg;
                // upper test wins when the bounds are crossed
                if (above) begin
                    drive_val_reg <= upper_bound_reg;
                    clamp_reg     <= ext_reg || pre_pos;
                end else if (below) begin
                    drive_val_reg <= lower_bound_reg;
                    clamp_reg     <= ext_reg || pre_neg;
                end else begin
                    drive_val_reg <= unsat_reg[31:0];
                    clamp_reg     <= ext_reg;
                end
            end
            STEP_ADD: begin
                incr_reg <= add_full[79:32];
            end
            STEP_COMMIT: begin
                out_drive_reg <= drive_val_reg;
            end
            default: begin
            end
        endcase
    end

    // integrator and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.step == STEP_COMMIT) begin
                if (rst_reg) begin
                    integ_reg <= '0;
                end else if (!clamp_reg) begin
                    integ_reg <= sum_sat;
                end
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_drive         = out_drive_reg;

endmodule
